### hdl/kce_pkg.sv
// ----------------------------------------------------------------------------
// kce_pkg: shared types and constants
// Register indexes, field widths and the sequencer state type of the
// kernel classifier evaluation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package kce_pkg;

    // field widths
    localparam int COORD_W  = 16;
    localparam int WEIGHT_W = 32;
    localparam int INDEX_W  = 10;
    localparam int NUM_COORD_FIELDS = 7;
    localparam int IN_DATA_W  = 160;
    localparam int OUT_DATA_W = 8;

    // arithmetic widths
    localparam int SUM_W  = 45;  // Q17.28 distance term
    localparam int PROD_W = 90;  // Q34.56 squared term
    localparam int REM_W  = 91;
    localparam int Q_W    = 33;
    localparam int ACC_W  = 48;
    localparam int MAG_W  = 32;
    localparam int NUM_BITS = 88;  // 32-bit magnitude shifted up by 56
    localparam int CHUNK_W  = 15;
    localparam int NUM_CHUNKS = 3;

    // register indexes
    localparam logic [1:0] REG_DIMS   = 2'd0;
    localparam logic [1:0] REG_ACTIVE = 2'd1;
    localparam logic [1:0] REG_OFFSET = 2'd2;

    // labels
    localparam logic [1:0] LABEL_POS  = 2'b01;
    localparam logic [1:0] LABEL_NEG  = 2'b11;
    localparam logic [1:0] LABEL_ZERO = 2'b00;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_FETCH = 7'b0000010,
        ST_SUM   = 7'b0000100,
        ST_MUL   = 7'b0001000,
        ST_DIV   = 7'b0010000,
        ST_ACC   = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

endpackage

`default_nettype wire

### hdl/kce_ram.sv
// ----------------------------------------------------------------------------
// kce_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kce_ram #(
    parameter int WIDTH = 144,
    parameter int DEPTH = 1024
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hdl/kernel_classifier_eval_unit.sv
// ----------------------------------------------------------------------------
// kernel_classifier_eval_unit: rational quadratic kernel classifier
// Stores support points in one RAM and scores a query point against the
// active points, returning the sign of the saturated weighted kernel sum.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  ---------+-----------+---------------------------------------------------
//  s_axis   | in        | load (store point) or query word
//  m_axis   | out       | label of a query
//  cfg      | in        | register index and write data
//
//  A load writes its point into the RAM as the word is accepted. A query
//  visits the n active points over d coordinates each; the bit-serial
//  divider takes 88 quotient steps per point unless the denominator is zero.
//  Reset clears control state and sets the registers to their defaults;
//  point storage holds garbage until loaded. A finished label waits in the
//  output register; a new word is taken once that label sits there.
// ----------------------------------------------------------------------------
`default_nettype none

module kernel_classifier_eval_unit #(
    parameter int MAX_POINTS = 1024,
    parameter int MAX_DIMS   = 7
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // fields from bit 0: point_index, coord_0..coord_6, weight, zero pad
    input  wire logic [kce_pkg::IN_DATA_W-1:0] s_tdata,
    // fields from bit 0: action
    input  wire logic                          s_tuser,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // fields from bit 0: label, zero pad
    output logic [kce_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [31:0]                   cfg_data
);

    import kce_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int JW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int DW = $clog2(MAX_DIMS + 1);
    localparam int ROW_W = MAX_DIMS * COORD_W + WEIGHT_W;

    // registers
    state_t                    st_reg, st_next;
    logic [2:0]                dims_reg;
    logic [10:0]               active_reg;
    logic [31:0]               offset_reg;
    logic [NW-1:0]             n_reg, p_reg;
    logic [DW-1:0]             d_reg, j_reg;
    logic signed [COORD_W-1:0] qc_reg [MAX_DIMS];
    logic [SUM_W-1:0]          s_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [1:0]                k_reg;
    logic                      neg_reg;
    logic [MAG_W-1:0]          mag_reg, magsh_reg;
    logic [REM_W-1:0]          rem_reg;
    logic [Q_W-1:0]            q_reg;
    logic                      over_reg;
    logic [6:0]                cnt_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic                      mvalid_reg;
    logic [1:0]                label_reg;

    // RAM
    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [ROW_W-1:0] ram_wdata, ram_rdata;
    logic [15:0]      idx16;

    kce_ram #(.WIDTH(ROW_W), .DEPTH(MAX_POINTS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic in_acc, is_query;
    assign s_tready  = (st_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_tvalid && s_tready;
    assign is_query  = s_tuser;
    assign idx16     = {6'b0, s_tdata[INDEX_W-1:0]};

    // load path: store all coordinates and the weight
    always_comb
    begin
        ram_wdata = '0;
        for (int i = 0; i < MAX_DIMS; i++)
        begin
            ram_wdata[i*COORD_W +: COORD_W] = s_tdata[INDEX_W + i*COORD_W +: COORD_W];
        end
        ram_wdata[MAX_DIMS*COORD_W +: WEIGHT_W] =
            s_tdata[INDEX_W + NUM_COORD_FIELDS*COORD_W +: WEIGHT_W];
    end
    assign ram_we    = in_acc && !is_query && (32'(idx16) < MAX_POINTS);
    assign ram_waddr = idx16[AW-1:0];
    assign ram_raddr = p_reg[AW-1:0];

    // effective counts at query start
    logic [NW-1:0] n_eff;
    logic [DW-1:0] d_eff;
    always_comb
    begin
        if (32'(active_reg) > MAX_POINTS)
            n_eff = NW'(MAX_POINTS);
        else
            n_eff = NW'(active_reg);
        if (dims_reg == 3'd0)
            d_eff = DW'(1);
        else if (32'(dims_reg) > MAX_DIMS)
            d_eff = DW'(MAX_DIMS);
        else
            d_eff = DW'(dims_reg);
    end

    // squared coordinate difference for the current dimension
    logic signed [COORD_W:0] diff;
    logic [COORD_W:0]        adiff;
    logic [2*COORD_W-1:0]    sq;
    always_comb
    begin
        diff  = 17'(signed'(ram_rdata[j_reg[JW-1:0]*COORD_W +: COORD_W]))
              - 17'(qc_reg[j_reg[JW-1:0]]);
        adiff = diff[COORD_W] ? 17'(-diff) : 17'(diff);
        sq    = adiff[COORD_W-1:0] * adiff[COORD_W-1:0];
    end

    // weight of the fetched point
    logic [WEIGHT_W-1:0] w_row;
    logic                w_neg;
    logic [MAG_W-1:0]    w_mag;
    assign w_row = ram_rdata[MAX_DIMS*COORD_W +: WEIGHT_W];
    assign w_neg = w_row[WEIGHT_W-1];
    assign w_mag = w_neg ? (~w_row + 32'd1) : w_row;

    // one partial product of s squared
    logic [CHUNK_W-1:0]        chunk;
    logic [SUM_W+CHUNK_W-1:0]  part;
    logic [PROD_W-1:0]         part_sh;
    always_comb
    begin
        case (k_reg)
            2'd0:    chunk = s_reg[0 +: CHUNK_W];
            2'd1:    chunk = s_reg[CHUNK_W +: CHUNK_W];
            2'd2:    chunk = s_reg[2*CHUNK_W +: CHUNK_W];
            default: chunk = '0;
        endcase
        part    = s_reg * chunk;
        part_sh = PROD_W'(part) << (CHUNK_W * 32'(k_reg));
    end

    // one restoring divide step
    logic [REM_W-1:0] rem_sh, rem_sub;
    logic             qbit;
    logic [Q_W-1:0]   q_sh;
    logic [Q_W-1:0]   cap;
    always_comb
    begin
        rem_sh  = {rem_reg[REM_W-2:0], magsh_reg[MAG_W-1]};
        rem_sub = rem_sh - {1'b0, prod_reg};
        qbit    = (rem_sh >= {1'b0, prod_reg});
        q_sh    = {q_reg[Q_W-2:0], qbit};
        cap     = neg_reg ? 33'h080000000 : 33'h07FFFFFFF;
    end

    // saturating accumulate
    logic [Q_W-1:0]          qm;
    logic signed [ACC_W:0]   acc_sum;
    logic signed [ACC_W-1:0] acc_sat;
    always_comb
    begin
        qm = over_reg ? cap : q_reg;
        if (neg_reg)
            acc_sum = 49'(acc_reg) - 49'(signed'({1'b0, qm}));
        else
            acc_sum = 49'(acc_reg) + 49'(signed'({1'b0, qm}));
        if (acc_sum > 49'sh07FFFFFFFFFFF)
            acc_sat = 48'sh7FFFFFFFFFFF;
        else if (acc_sum < -49'sh0800000000000)
            acc_sat = 48'sh800000000000;
        else
            acc_sat = acc_sum[ACC_W-1:0];
    end

    // sequencer next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:
                if (in_acc && is_query)
                    st_next = (n_eff == '0) ? ST_DONE : ST_FETCH;
            ST_FETCH: st_next = ST_SUM;
            ST_SUM:
                if (j_reg == d_reg - DW'(1))
                    st_next = ST_MUL;
            ST_MUL:
                if (k_reg == 2'(NUM_CHUNKS - 1))
                    st_next = ((prod_reg + part_sh) == '0) ? ST_ACC : ST_DIV;
            ST_DIV:
                if (cnt_reg == 7'd1)
                    st_next = ST_ACC;
            ST_ACC:
                st_next = (p_reg + NW'(1) == n_reg) ? ST_DONE : ST_FETCH;
            ST_DONE:
                if (!mvalid_reg || m_tready)
                    st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_IDLE;
            dims_reg   <= 3'd7;
            active_reg <= 11'd0;
            offset_reg <= 32'd65536;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            // take configuration writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_DIMS:   dims_reg   <= cfg_data[2:0];
                    REG_ACTIVE: active_reg <= cfg_data[10:0];
                    REG_OFFSET: offset_reg <= cfg_data;
                    default:    ;
                endcase
            end
            // hold the label until taken
            if (st_reg == ST_DONE && (!mvalid_reg || m_tready))
                mvalid_reg <= 1'b1;
            else if (m_tready)
                mvalid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (st_reg)
            ST_IDLE:
            begin
                if (in_acc && is_query)
                begin
                    for (int i = 0; i < MAX_DIMS; i++)
                        qc_reg[i] <= signed'(s_tdata[INDEX_W + i*COORD_W +: COORD_W]);
                    n_reg   <= n_eff;
                    d_reg   <= d_eff;
                    p_reg   <= '0;
                    acc_reg <= '0;
                end
            end
            ST_FETCH:
            begin
                s_reg <= {1'b0, offset_reg, 12'b0};
                j_reg <= '0;
            end
            ST_SUM:
            begin
                s_reg    <= s_reg + SUM_W'(sq);
                j_reg    <= j_reg + DW'(1);
                neg_reg  <= w_neg;
                mag_reg  <= w_mag;
                k_reg    <= '0;
                prod_reg <= '0;
            end
            ST_MUL:
            begin
                prod_reg  <= prod_reg + part_sh;
                k_reg     <= k_reg + 2'd1;
                magsh_reg <= mag_reg;
                rem_reg   <= '0;
                q_reg     <= '0;
                cnt_reg   <= 7'(NUM_BITS);
                // zero denominator: saturate, or nothing for a zero weight
                over_reg  <= (mag_reg != '0);
            end
            ST_DIV:
            begin
                if (qbit)
                    rem_reg <= rem_sub;
                else
                    rem_reg <= rem_sh;
                magsh_reg <= {magsh_reg[MAG_W-2:0], 1'b0};
                cnt_reg   <= cnt_reg - 7'd1;
                // first step restarts the overflow flag; later steps freeze q once over
                if (cnt_reg == 7'(NUM_BITS))
                begin
                    q_reg    <= q_sh;
                    over_reg <= (q_sh > cap);
                end
                else if (!over_reg)
                begin
                    q_reg <= q_sh;
                    if (q_sh > cap)
                        over_reg <= 1'b1;
                end
            end
            ST_ACC:
            begin
                acc_reg <= acc_sat;
                p_reg   <= p_reg + NW'(1);
            end
            ST_DONE:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    if (acc_reg > 0)
                        label_reg <= LABEL_POS;
                    else if (acc_reg < 0)
                        label_reg <= LABEL_NEG;
                    else
                        label_reg <= LABEL_ZERO;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {6'b0, label_reg};

    // checks
    a_we_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> st_reg == ST_IDLE)
        else $error("point store written outside idle");
    a_label_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(st_reg == ST_DONE))
        else $error("label raised without a finished query");
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == ST_ACC |-> qm <= cap)
        else $error("quotient above saturation cap");

endmodule

`default_nettype wire

### verif/kce_checker.sv
// ----------------------------------------------------------------------------
// kce_checker: label predictor and scoreboard
// Watches the load/query, label and register channels of the kernel
// classifier, keeps its own copy of support points and registers, predicts
// the label of every query word and compares it with the label word seen.
// ----------------------------------------------------------------------------
`default_nettype none

module kce_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [kce_pkg::IN_DATA_W-1:0] s_tdata,
    input  wire logic                          s_tuser,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic [kce_pkg::OUT_DATA_W-1:0] m_tdata,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic                          cfg_valid,
    input  wire logic                          cfg_ready,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [31:0]                   cfg_data,
    output int                                 errors,
    output int                                 pending
);
    import kce_pkg::*;

    localparam int NPTS = 1024;
    localparam longint SCORE_MAX = 64'sh7FFF_FFFF_FFFF;
    localparam longint SCORE_MIN = -SCORE_MAX - 1;

    logic [15:0] coord_mem [NPTS][7];
    logic [31:0] weight_mem [NPTS];
    logic [2:0]  dims_q;
    logic [10:0] active_q;
    logic [31:0] offset_q;

    // expected labels in a small ring, written at the query, read at the label
    logic [1:0]  labels_due [16];
    logic [3:0]  due_wr;
    logic [3:0]  due_rd;
    logic [3:0]  due_cnt;

    // sign of the saturated weighted kernel sum for one query point
    function automatic logic [1:0] score_sign(input logic [6:0][15:0] q);
        longint acc;
        int n;
        int d;
        logic [44:0] s;
        logic [127:0] den;
        logic [127:0] num;
        logic [127:0] quo;
        logic [31:0] w;
        logic [32:0] mag;
        logic [32:0] cap;
        logic [32:0] qm;
        logic signed [16:0] diff;
        logic [16:0] ad;
        acc = 0;
        n = (active_q > NPTS) ? NPTS : int'(active_q);
        d = (dims_q == 0) ? 1 : int'(dims_q);
        for (int p = 0; p < n; p++)
        begin
            s = {1'b0, offset_q, 12'd0};
            for (int j = 0; j < d; j++)
            begin
                diff = $signed({coord_mem[p][j][15], coord_mem[p][j]})
                     - $signed({q[j][15], q[j]});
                ad = diff[16] ? 17'(-diff) : 17'(diff);
                s = s + 45'(ad) * 45'(ad);
            end
            w = weight_mem[p];
            if (w == 0)
                continue;
            mag = w[31] ? 33'h1_0000_0000 - 33'(w) : 33'(w);
            cap = w[31] ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
            den = 128'(s) * 128'(s);
            if (den == 0)
                qm = cap;
            else
            begin
                num = 128'(mag) << 56;
                quo = num / den;
                qm = (quo > 128'(cap)) ? cap : 33'(quo);
            end
            acc = w[31] ? acc - longint'(qm) : acc + longint'(qm);
            if (acc > SCORE_MAX)
                acc = SCORE_MAX;
            if (acc < SCORE_MIN)
                acc = SCORE_MIN;
        end
        if (acc > 0)
            return LABEL_POS;
        else if (acc < 0)
            return LABEL_NEG;
        return LABEL_ZERO;
    endfunction

    assign due_cnt = due_wr - due_rd;
    assign pending = int'(due_cnt);

    always @(posedge clk or negedge rst_n)
    begin
        logic [6:0][15:0] q;
        logic [7:0] want;
        if (!rst_n)
        begin
            dims_q   <= 3'd7;
            active_q <= 11'd0;
            offset_q <= 32'd65536;
            errors   <= 0;
            due_wr   <= 4'd0;
            due_rd   <= 4'd0;
        end
        else
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_DIMS:   dims_q   <= cfg_data[2:0];
                    REG_ACTIVE: active_q <= cfg_data[10:0];
                    REG_OFFSET: offset_q <= cfg_data;
                    default: ;
                endcase
            end
            // load or query word
            if (s_tvalid && s_tready)
            begin
                q = s_tdata[121:10];
                if (!s_tuser)
                begin
                    for (int j = 0; j < 7; j++)
                        coord_mem[s_tdata[9:0]][j] = q[j];
                    weight_mem[s_tdata[9:0]] = s_tdata[153:122];
                end
                else
                begin
                    labels_due[due_wr] <= score_sign(q);
                    due_wr <= due_wr + 4'd1;
                end
            end
            // label word
            if (m_tvalid && m_tready)
            begin
                if (due_cnt == 4'd0)
                begin
                    if (errors < 10)
                        $display("label word %h with no query outstanding", m_tdata);
                    errors <= errors + 1;
                end
                else
                begin
                    want = {6'd0, labels_due[due_rd]};
                    due_rd <= due_rd + 4'd1;
                    if (m_tdata !== want)
                    begin
                        if (errors < 10)
                            $display("label mismatch: expected %h actual %h", want, m_tdata);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: kernel classifier evaluation unit testbench
// Drives support point loads, queries and register writes with random idling
// on both stream sides; the checker predicts and compares every label.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import kce_pkg::*;

    localparam longint CYCLE_LIMIT = 2_000_000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic m_tvalid;
    logic m_tready = 1'b1;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int errors;
    int pending;
    bit idle_en = 1'b0;
    longint cycles = 0;

    // points held in the low slots, used to aim queries close to them
    logic [6:0][15:0] near_c [8];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    kernel_classifier_eval_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    kce_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // label side backpressure in random bursts
    always @(posedge clk)
    begin
        int hold;
        hold = 0;
        if (idle_en && $urandom_range(0, 7) == 0)
        begin
            hold = $urandom_range(1, 14);
            m_tready <= 1'b0;
            repeat (hold) @(posedge clk);
        end
        m_tready <= 1'b1;
    end

    // send one word, with a random gap in front of it; ends any register write
    task automatic send_word(input logic act, input logic [9:0] slot,
                             input logic [6:0][15:0] c, input logic [31:0] w);
        int gap;
        gap = 0;
        cfg_valid <= 1'b0;
        if (idle_en && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 14);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {6'd0, w, c, slot};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic load_point(input logic [9:0] slot, input logic [6:0][15:0] c,
                              input logic [31:0] w);
        if (slot < 8)
            near_c[slot] = c;
        send_word(1'b0, slot, c, w);
    endtask

    // block idle: lower valid, drain labels, let a load settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // hold valid across back to back writes; the next word drops it
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    function automatic logic [6:0][15:0] rand_coords();
        logic [6:0][15:0] c;
        for (int j = 0; j < 7; j++)
            c[j] = 16'($urandom);
        return c;
    endfunction

    // query aimed close to one of the low slots
    function automatic logic [6:0][15:0] near_coords();
        logic [6:0][15:0] c;
        int k;
        k = $urandom_range(0, 7);
        for (int j = 0; j < 7; j++)
            c[j] = near_c[k][j] + 16'($urandom_range(0, 256)) - 16'd128;
        return c;
    endfunction

    function automatic logic [31:0] pick_offset();
        case ($urandom_range(0, 4))
            0: return 32'd1;
            1: return 32'd65536;
            2: return 32'hFFFF_FFFF;
            3: return 32'($urandom_range(1, 4096));
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: query with no active points at reset settings
        send_word(1'b1, 10'd0, rand_coords(), 32'd0);
        load_point(10'd0, {7{16'h7FFF}}, 32'h7FFF_FFFF);
        load_point(10'd1, {7{16'h8000}}, 32'h8000_0000);
        load_point(10'd2, {7{16'h0000}}, 32'd0);
        for (int k = 3; k < 8; k++)
            load_point(10'(k), rand_coords(), $urandom);
        drain();
        write_reg(REG_ACTIVE, 32'd8);
        send_word(1'b1, 10'd0, {7{16'h7FFF}}, 32'd0);
        send_word(1'b1, 10'd0, {7{16'h8000}}, 32'd0);
        send_word(1'b1, 10'd0, {7{16'h0000}}, 32'd0);
        send_word(1'b1, 10'd1023, near_c[4], 32'hFFFF_FFFF);
        // zero denominator: offset zero and a query equal to a stored point
        drain();
        write_reg(REG_OFFSET, 32'd0);
        write_reg(REG_ACTIVE, 32'd3);
        send_word(1'b1, 10'd0, {7{16'h7FFF}}, 32'd0);
        send_word(1'b1, 10'd0, {7{16'h0000}}, 32'd0);
        send_word(1'b1, 10'd0, {7{16'h8000}}, 32'd0);
        // dims zero acts as one
        drain();
        write_reg(REG_DIMS, 32'd0);
        write_reg(REG_OFFSET, 32'hFFFF_FFFF);
        write_reg(REG_ACTIVE, 32'd8);
        send_word(1'b1, 10'd0, near_c[3], 32'd0);
        send_word(1'b1, 10'd0, rand_coords(), 32'd0);
        drain();

        // random phases over several register settings; the last one runs flat out
        for (int ph = 0; ph < 6; ph++)
        begin
            idle_en = (ph != 0) && (ph != 5);
            write_reg(REG_DIMS, (ph == 1) ? 32'd1 : (ph == 2) ? 32'd7
                                : 32'($urandom_range(0, 7)));
            write_reg(REG_ACTIVE, 32'($urandom_range(1, 8)));
            write_reg(REG_OFFSET, pick_offset());
            for (int i = 0; i < 94; i++)
            begin
                case ($urandom_range(0, 9))
                    0, 1: load_point(10'($urandom_range(0, 7)),
                                     ($urandom_range(0, 1) ? near_coords() : rand_coords()),
                                     $urandom);
                    2: load_point(10'($urandom_range(8, 1023)), rand_coords(), $urandom);
                    3, 4: send_word(1'b1, 10'($urandom), rand_coords(), $urandom);
                    default: send_word(1'b1, 10'($urandom), near_coords(), $urandom);
                endcase
            end
            drain();
        end

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
hdl/kce_pkg.sv
hdl/kce_ram.sv
hdl/kernel_classifier_eval_unit.sv
verif/kce_checker.sv
verif/tb_top.sv
